FILE: sv/tcp_pkg.sv
// Package for the timed pump command parser.
// Opcodes, character codes, defaults and the parser-to-pump-bank command type.
// No dependencies.
`default_nettype none

package tcp_pkg;

    // item opcodes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;
    localparam logic [1:0] OP_ALL_OFF = 2'd3;

    // characters of the command line
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int         PUMP_COUNT_DEF = 4;
    localparam logic [7:0] PWM_DUTY_RESET = 8'hFF;

    // finished command from the parser
    typedef struct packed {
        logic        fire;
        logic [7:0]  pump_num;
        logic [31:0] duration;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/tcp_if.sv
// Valid/ready channel interfaces for the timed pump command parser.
// Payload widths are fixed; no dependencies.
`default_nettype none

interface tcp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_value;

    modport source (output valid, output opcode, output byte_value, input ready);
    modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface tcp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  pump_on_mask;
    logic [7:0]  drive_duty;
    logic        line_done;
    logic [31:0] latest_off_time;

    modport source (output valid, output pump_on_mask, output drive_duty,
                    output line_done, output latest_off_time, input ready);
    modport sink   (input valid, input pump_on_mask, input drive_duty,
                    input line_done, input latest_off_time, output ready);
endinterface

`default_nettype wire

FILE: sv/timed_pump_command_parser.sv
// Top level of the timed pump command parser: input register, parser,
// pump bank and result register. Uses tcp_pkg, tcp_if, tcp_parser, tcp_pump_bank.
//
//   channel   dir  handshake        payload
//   i_in      in   valid/ready      opcode[1:0], byte_value[7:0]
//   o_out     out  valid/ready      pump_on_mask[3:0], drive_duty[7:0],
//                                   line_done, latest_off_time[31:0]
//   cfg       in   i_cfg_we         i_cfg_wdata[7:0] (pwm_duty)
//
// One item per cycle while the result side is not stalled, one result item
// per item. An item sits in the input register, is processed in one pass and
// is then registered in the result register. i_in.ready drops only while
// both registers are full and the result item is not being taken.
// Synchronous active-low reset empties both registers, clears the counter,
// the on mask and the parser, and sets pwm_duty to 255.
`default_nettype none

module timed_pump_command_parser #(
    parameter int PUMP_COUNT = tcp_pkg::PUMP_COUNT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tcp_in_if.sink          i_in,
    tcp_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_opcode;
    logic [7:0] r_in_byte;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_out_mask;
    logic [7:0]  r_out_duty;
    logic        r_out_done;
    logic [31:0] r_out_latest;

    logic [7:0]  r_pwm_duty;

    logic                    advance;   // result register can take a new item
    logic                    step;      // held item is processed this cycle
    tcp_pkg::t_cmd           cmd;
    logic [PUMP_COUNT-1:0]   mask_next;
    logic [31:0]             line_max_next;
    logic [PUMP_COUNT+3:0]   mask_pad;  // zero-extended so low 4 bits always exist

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_opcode <= i_in.opcode;
            r_in_byte   <= i_in.byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_duty <= tcp_pkg::PWM_DUTY_RESET;
        end else if (i_cfg_we) begin
            r_pwm_duty <= i_cfg_wdata;
        end
    end

    tcp_parser #(
        .PUMP_COUNT (PUMP_COUNT)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_opcode (r_in_opcode),
        .i_byte   (r_in_byte),
        .o_cmd    (cmd)
    );

    tcp_pump_bank #(
        .PUMP_COUNT (PUMP_COUNT)
    ) u_pump_bank (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_opcode        (r_in_opcode),
        .i_cmd           (cmd),
        .o_mask_next     (mask_next),
        .o_line_max_next (line_max_next)
    );

    assign mask_pad = {4'b0, mask_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // latest off time shows only on end of line results
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_mask   <= mask_pad[3:0];
            r_out_duty   <= r_pwm_duty;
            r_out_done   <= (r_in_opcode == tcp_pkg::OP_END);
            r_out_latest <= (r_in_opcode == tcp_pkg::OP_END) ? line_max_next : 32'd0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.pump_on_mask    = r_out_mask;
    assign o_out.drive_duty      = r_out_duty;
    assign o_out.line_done       = r_out_done;
    assign o_out.latest_off_time = r_out_latest;

endmodule

`default_nettype wire

FILE: sv/tcp_parser.sv
// Command line parser: phase register, pump number and duration accumulators.
// Uses tcp_pkg; emits a tcp_pkg::t_cmd when a command completes.
`default_nettype none

module tcp_parser #(
    parameter int PUMP_COUNT = tcp_pkg::PUMP_COUNT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [7:0]   i_byte,
    output tcp_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_PUMP = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_DUR  = 2'd3;

    localparam logic [7:0] MAX_NUM = 8'(PUMP_COUNT);

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_pacc, n_pacc;
    logic [31:0] r_dacc, n_dacc;
    logic        r_has, n_has;

    logic        digit, is_p, is_colon, num_good;
    logic [3:0]  dval;
    logic [7:0]  dsub;
    logic [11:0] pnext;
    logic [7:0]  psat;
    logic [31:0] dnext;

    assign digit    = (i_byte >= tcp_pkg::CH_ZERO) && (i_byte <= tcp_pkg::CH_NINE);
    assign is_p     = (i_byte == tcp_pkg::CH_UPPER_P) || (i_byte == tcp_pkg::CH_LOWER_P);
    assign is_colon = (i_byte == tcp_pkg::CH_COLON);
    assign dsub     = i_byte - tcp_pkg::CH_ZERO;
    assign dval     = dsub[3:0];
    assign num_good = (r_pacc != 8'd0) && (r_pacc <= MAX_NUM);

    // acc*10 + digit, saturating at 255
    assign pnext = ({4'b0, r_pacc} << 3) + ({4'b0, r_pacc} << 1) + {8'b0, dval};
    assign psat  = (pnext > 12'd255) ? 8'hFF : pnext[7:0];
    // wraps modulo 2^32
    assign dnext = (r_dacc << 3) + (r_dacc << 1) + {28'b0, dval};

    always_comb begin
        n_phase         = r_phase;
        n_pacc          = r_pacc;
        n_dacc          = r_dacc;
        n_has           = r_has;
        o_cmd.fire      = 1'b0;
        o_cmd.pump_num  = r_pacc;
        o_cmd.duration  = r_dacc;
        if (i_step) begin
            case (i_opcode)
                tcp_pkg::OP_BYTE: begin
                    case (r_phase)
                        PH_SEEK: begin
                            if (is_p) begin
                                n_phase = PH_PUMP;
                                n_pacc  = 8'd0;
                            end
                        end
                        PH_PUMP: begin
                            if (digit) begin
                                n_pacc = psat;
                            end else if (!num_good) begin
                                // byte seen again while seeking P
                                if (is_p) begin
                                    n_pacc = 8'd0;
                                end else begin
                                    n_phase = PH_SEEK;
                                end
                            end else if (is_colon) begin
                                n_phase = PH_DUR;
                                n_dacc  = 32'd0;
                                n_has   = 1'b0;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            if (is_colon) begin
                                n_phase = PH_DUR;
                                n_dacc  = 32'd0;
                                n_has   = 1'b0;
                            end
                        end
                        default: begin
                            if (digit) begin
                                n_dacc = dnext;
                                n_has  = 1'b1;
                            end else begin
                                o_cmd.fire = r_has && num_good;
                                if (is_p) begin
                                    n_phase = PH_PUMP;
                                    n_pacc  = 8'd0;
                                end else begin
                                    n_phase = PH_SEEK;
                                end
                            end
                        end
                    endcase
                end
                tcp_pkg::OP_END: begin
                    o_cmd.fire = (r_phase == PH_DUR) && r_has && num_good;
                    n_phase    = PH_SEEK;
                    n_pacc     = 8'd0;
                    n_dacc     = 32'd0;
                    n_has      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_pacc  <= 8'd0;
            r_dacc  <= 32'd0;
            r_has   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pacc  <= n_pacc;
            r_dacc  <= n_dacc;
            r_has   <= n_has;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcp_pump_bank.sv
// Pump lanes: millisecond counter, per-pump off time and on bit, line maximum.
// Uses tcp_pkg; takes commands from tcp_parser.
`default_nettype none

module tcp_pump_bank #(
    parameter int PUMP_COUNT = tcp_pkg::PUMP_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [1:0]            i_opcode,
    input  wire tcp_pkg::t_cmd         i_cmd,
    output logic [PUMP_COUNT-1:0]      o_mask_next,
    output logic [31:0]                o_line_max_next
);

    logic [31:0]           r_time, n_time;
    logic [PUMP_COUNT-1:0] r_mask, n_mask;
    logic [31:0]           r_off [PUMP_COUNT];
    logic [31:0]           n_off [PUMP_COUNT];
    logic [31:0]           r_line, n_line;
    logic [31:0]           time_inc, sched;
    logic [31:0]           diff [PUMP_COUNT];

    assign time_inc = r_time + 32'd1;
    assign sched    = r_time + i_cmd.duration;

    always_comb begin
        n_time = r_time;
        n_mask = r_mask;
        n_line = r_line;
        for (int i = 0; i < PUMP_COUNT; i++) begin
            n_off[i] = r_off[i];
            diff[i]  = time_inc - r_off[i];
        end
        if (i_step) begin
            case (i_opcode)
                tcp_pkg::OP_TICK: begin
                    n_time = time_inc;
                    // signed wrap compare: expired once time - off >= 0
                    for (int i = 0; i < PUMP_COUNT; i++) begin
                        if (r_mask[i] && !diff[i][31]) begin
                            n_mask[i] = 1'b0;
                        end
                    end
                end
                tcp_pkg::OP_ALL_OFF: begin
                    n_mask = '0;
                end
                default: begin
                    if (i_cmd.fire) begin
                        for (int i = 0; i < PUMP_COUNT; i++) begin
                            if (i_cmd.pump_num == 8'(i + 1)) begin
                                if (i_cmd.duration == 32'd0) begin
                                    n_mask[i] = 1'b0;
                                end else begin
                                    n_mask[i] = 1'b1;
                                    n_off[i]  = sched;
                                end
                            end
                        end
                        if ((i_cmd.duration != 32'd0) && (sched > r_line)) begin
                            n_line = sched;
                        end
                    end
                end
            endcase
        end
    end

    assign o_mask_next     = n_mask;
    assign o_line_max_next = n_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= 32'd0;
            r_mask <= '0;
            r_line <= 32'd0;
        end else begin
            r_time <= n_time;
            r_mask <= n_mask;
            r_line <= (i_step && (i_opcode == tcp_pkg::OP_END)) ? 32'd0 : n_line;
        end
    end

    // off times matter only while the on bit is set
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PUMP_COUNT; i++) begin
            r_off[i] <= n_off[i];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcp_checker.sv
// Port-level checker for timed_pump_command_parser, attached with bind.
// Depends only on the top level's ports.
`default_nettype none

module tcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_out_mask,
    input wire logic [7:0]  i_out_duty,
    input wire logic        i_out_done,
    input wire logic [31:0] i_out_latest
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mask)
            && $stable(i_out_duty) && $stable(i_out_done) && $stable(i_out_latest))
        else $error("result changed while stalled");

    // off time is reported only on end of line
    a_latest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_done |-> i_out_latest == 32'd0)
        else $error("latest off time on a non end of line result");

    // input side never blocks while the output side can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled with free result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind timed_pump_command_parser tcp_checker u_tcp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_mask   (o_out.pump_on_mask),
    .i_out_duty   (o_out.drive_duty),
    .i_out_done   (o_out.line_done),
    .i_out_latest (o_out.latest_off_time)
);

`default_nettype wire

FILE: bench/timed_pump_command_parser_tb.sv
// Testbench for timed_pump_command_parser: directed command lines, then random lines,
// ticks and noise with random idling, checked against a cycle-free predictor.
// Depends on tcp_pkg, tcp_if and the parser RTL.
module timed_pump_command_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PUMPS        = tcp_pkg::PUMP_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no item moving on either side
    localparam int LONG_HOLD      = 64;     // receiver hold-off, well past the block's depth

    // predictor parse phases
    localparam logic [1:0] SEEK_P        = 2'd0;
    localparam logic [1:0] READ_PUMP     = 2'd1;
    localparam logic [1:0] SKIP_TO_COLON = 2'd2;
    localparam logic [1:0] READ_DURATION = 2'd3;

    typedef struct packed {
        logic [3:0]  pump_on_mask;
        logic [7:0]  drive_duty;
        logic        line_done;
        logic [31:0] latest_off_time;
    } t_pump_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    tcp_in_if  cmd_ch ();
    tcp_out_if status_ch ();

    timed_pump_command_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch),
        .o_out       (status_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a copy of the parser, the pump bank and the duty.
    // ------------------------------------------------------------------
    logic [31:0]        ms_count;
    logic [31:0]        pump_deadline [N_PUMPS];
    logic [N_PUMPS-1:0] pumps_on;
    logic [1:0]         phase;
    logic [7:0]         pump_num;
    logic [31:0]        run_ms;
    logic               run_has_digits;
    logic [31:0]        line_latest;
    logic [7:0]         duty_level;

    t_pump_status expected_status [$];
    int unsigned  mismatches   = 0;
    int unsigned  items_sent   = 0;
    int unsigned  quiet_cycles = 0;

    // Idling controls; both are dropped for the last stretch of the run.
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    bit hold_request    = 1'b0;

    function automatic void reset_predictor();
        ms_count       = '0;
        pumps_on       = '0;
        phase          = SEEK_P;
        pump_num       = '0;
        run_ms         = '0;
        run_has_digits = 1'b0;
        line_latest    = '0;
        duty_level     = tcp_pkg::PWM_DUTY_RESET;
        foreach (pump_deadline[i])
            pump_deadline[i] = '0;
    endfunction

    function automatic void clear_pump(int idx);
        pumps_on[idx]      = 1'b0;
        pump_deadline[idx] = '0;
    endfunction

    // Commits a command that has its colon: zero duration switches off,
    // anything else schedules a deadline (wrapping mod 2^32).
    function automatic void apply_command();
        int idx;
        if (!run_has_digits || pump_num == 0 || pump_num > N_PUMPS)
            return;
        idx = int'(pump_num) - 1;
        if (run_ms == 0) begin
            clear_pump(idx);
        end else begin
            pumps_on[idx]      = 1'b1;
            pump_deadline[idx] = ms_count + run_ms;
            if (pump_deadline[idx] > line_latest)
                line_latest = pump_deadline[idx];
        end
    endfunction

    // One pass of a character through the current phase. Returns 0 when the
    // character closed a field and has to go through the next phase again.
    function automatic bit consume_char(logic [7:0] c);
        bit          digit;
        int unsigned acc;
        digit = (c >= tcp_pkg::CH_ZERO) && (c <= tcp_pkg::CH_NINE);
        case (phase)
            SEEK_P: begin
                if (c == tcp_pkg::CH_UPPER_P || c == tcp_pkg::CH_LOWER_P) begin
                    phase    = READ_PUMP;
                    pump_num = '0;
                end
                return 1'b1;
            end
            READ_PUMP: begin
                if (digit) begin
                    acc      = 32'(pump_num) * 10 + 32'(c) - 32'(tcp_pkg::CH_ZERO);
                    pump_num = (acc > 255) ? 8'd255 : 8'(acc);
                    return 1'b1;
                end
                if (pump_num == 0 || pump_num > N_PUMPS)
                    phase = SEEK_P;
                else
                    phase = SKIP_TO_COLON;
                return 1'b0;
            end
            SKIP_TO_COLON: begin
                if (c == tcp_pkg::CH_COLON) begin
                    phase          = READ_DURATION;
                    run_ms         = '0;
                    run_has_digits = 1'b0;
                end
                return 1'b1;
            end
            default: begin
                if (digit) begin
                    run_ms         = run_ms * 32'd10 + 32'(c - tcp_pkg::CH_ZERO);
                    run_has_digits = 1'b1;
                    return 1'b1;
                end
                apply_command();
                phase = SEEK_P;
                return 1'b0;
            end
        endcase
    endfunction

    // Expected status item for one accepted command item.
    function automatic t_pump_status predict_status(logic [1:0] op, logic [7:0] value);
        t_pump_status st;
        logic [31:0]  lag;
        int           k;
        st = '0;
        case (op)
            tcp_pkg::OP_BYTE: begin
                for (k = 0; k < 3; k++)
                    if (consume_char(value))
                        break;
            end
            tcp_pkg::OP_TICK: begin
                ms_count = ms_count + 32'd1;
                // signed wrap compare: expired once the counter is not behind
                for (k = 0; k < N_PUMPS; k++) begin
                    lag = ms_count - pump_deadline[k];
                    if (pumps_on[k] && !lag[31])
                        clear_pump(k);
                end
            end
            tcp_pkg::OP_END: begin
                if (phase == READ_DURATION)
                    apply_command();
                phase              = SEEK_P;
                pump_num           = '0;
                run_ms             = '0;
                run_has_digits     = 1'b0;
                st.line_done       = 1'b1;
                st.latest_off_time = line_latest;
                line_latest        = '0;
            end
            default: begin
                // all off keeps the parser and the line maximum
                for (k = 0; k < N_PUMPS; k++)
                    clear_pump(k);
            end
        endcase
        st.pump_on_mask = 4'(pumps_on);
        st.drive_duty   = duty_level;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Each status item taken is compared with the oldest expectation.
    always @(posedge i_clk) begin : status_checker
        t_pump_status want;
        if (i_rst_n && status_ch.valid && status_ch.ready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("status item with no command item pending");
            end else begin
                want = expected_status.pop_front();
                check_field("pump_on_mask", 32'(status_ch.pump_on_mask),
                            32'(want.pump_on_mask));
                check_field("drive_duty", 32'(status_ch.drive_duty), 32'(want.drive_duty));
                check_field("line_done", 32'(status_ch.line_done), 32'(want.line_done));
                check_field("latest_off_time", status_ch.latest_off_time,
                            want.latest_off_time);
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: short random stalls, or one long hold-off when asked for.
    initial begin : status_receiver
        forever begin
            if (hold_request) begin
                status_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                status_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            status_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offers one item, waits for the handshake, then predicts its status.
    task automatic send_item(logic [1:0] op, logic [7:0] value);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.byte_value <= value;
        do @(posedge i_clk); while (!cmd_ch.ready);
        expected_status.push_back(predict_status(op, value));
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        send_item(tcp_pkg::OP_BYTE, c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_decimal(logic [31:0] v);
        logic [7:0] digits [$];
        do begin
            digits.push_front(tcp_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i])
            send_byte(digits[i]);
    endtask

    task automatic send_random_digits(int unsigned count);
        repeat (count)
            send_byte(tcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] random_non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c >= tcp_pkg::CH_ZERO && c <= tcp_pkg::CH_NINE);
        return c;
    endfunction

    // One command, mostly well formed; the rest has bad numbers, a missing
    // colon or missing duration digits.
    task automatic send_random_command();
        int unsigned pick;
        send_byte($urandom_range(0, 1) ? tcp_pkg::CH_UPPER_P : tcp_pkg::CH_LOWER_P);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            send_byte(tcp_pkg::CH_ZERO + 8'($urandom_range(1, N_PUMPS)));
        end else if (pick == 7) begin
            send_random_digits($urandom_range(1, 4));   // zero, too high, saturating
        end else if (pick == 8) begin
            send_byte(tcp_pkg::CH_ZERO);                 // leading zero
            send_byte(tcp_pkg::CH_ZERO + 8'($urandom_range(0, N_PUMPS + 1)));
        end
        repeat ($urandom_range(0, 2))
            send_byte(random_non_digit());
        if ($urandom_range(0, 9) != 0)
            send_byte(tcp_pkg::CH_COLON);
        case ($urandom_range(0, 11))
            0: send_byte(tcp_pkg::CH_ZERO);                // switch off
            1: ;                                           // no duration digits
            2: send_random_digits($urandom_range(8, 12));  // wraps mod 2^32
            3: send_decimal(32'd0 - ms_count);             // deadline lands on zero
            4: send_decimal($urandom);                     // may sit past half range
            default: send_decimal($urandom_range(1, 30));
        endcase
    endtask

    task automatic send_random_line();
        repeat ($urandom_range(1, 3)) begin
            send_random_command();
            if ($urandom_range(0, 1))
                send_byte(random_non_digit());
        end
        if ($urandom_range(0, 7) != 0)
            send_item(tcp_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Drops valid and waits until every expected status item has been taken.
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge i_clk);
    endtask

    // Duty is only changed with the block drained.
    task automatic set_pwm_duty(logic [7:0] level);
        wait_for_results();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= level;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        duty_level  = level;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_command_fields();
        // pump 2 for 3 ms; the 'p' closing the duration opens a command
        // that never reaches a colon before end of line
        send_text("P2:3p");
        send_item(tcp_pkg::OP_END, 8'h00);
        // pump 0 is dropped and its closing 'P' starts over; 256 saturates
        // to 255, so the colon and the digit after it are ignored
        send_text("P0P256:1");
        // skipped 0xFF, then a zero byte right after the colon: no digits
        send_text("p4");
        send_byte(8'hFF);
        send_byte(tcp_pkg::CH_COLON);
        send_byte(8'h00);
        send_item(tcp_pkg::OP_END, 8'hFF);
    endtask

    task automatic test_tick_expiry();
        // pump 2 from the first line expires on the third tick
        repeat (3)
            send_item(tcp_pkg::OP_TICK, 8'hFF);
    endtask

    task automatic test_all_off();
        // all off in the middle of a duration: the parser keeps going and
        // end of line switches pump 3 back on
        send_text("P3:9");
        send_item(tcp_pkg::OP_ALL_OFF, 8'($urandom_range(0, 255)));
        send_item(tcp_pkg::OP_END, 8'($urandom_range(0, 255)));
        // zero duration switches it off again
        send_text("P3:0");
        send_item(tcp_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_lines(int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 4))
                       send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                1: send_item(tcp_pkg::OP_ALL_OFF, 8'($urandom_range(0, 255)));
                default: send_random_line();
            endcase
            repeat ($urandom_range(0, 10))
                send_item(tcp_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver holds off while lines keep coming, so the block fills up and
    // stalls its input; then the sender waits for everything to drain.
    task automatic test_backpressure();
        int unsigned stop_at;
        hold_request = 1'b1;
        stop_at = items_sent + 40;
        while (items_sent < stop_at)
            send_random_line();
        wait_for_results();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= tcp_pkg::OP_BYTE;
        cmd_ch.byte_value <= '0;
        reset_predictor();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_command_fields();
        test_tick_expiry();
        test_all_off();

        set_pwm_duty(8'h00);
        test_random_lines(300);

        set_pwm_duty(8'($urandom_range(1, 254)));
        test_backpressure();

        set_pwm_duty(8'hFF);
        test_random_lines(250);

        // last stretch at full rate on both sides
        wait_for_results();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        set_pwm_duty(8'($urandom_range(0, 255)));
        test_random_lines(220);

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
